/* hw/rtl/pofb_pkg.sv */
// Package for the pulsed output force bank: channel count, operation and
// status codes, and the layout of one stored channel entry.
// No dependencies.
`default_nettype none

package pofb_pkg;

   localparam int CHANNELS = 64;
   localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [7:0] TICK_MS_RESET = 8'd20;

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_PULSE   = 3'd1,
      OP_FORCE   = 3'd2,
      OP_UNFORCE = 3'd3,
      OP_SETMARK = 3'd4,
      OP_READ    = 3'd5,
      OP_TICK    = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   // One channel as held in the state memory.
   typedef struct packed {
      logic        out_level;
      logic        forced;
      logic [15:0] timer;
   } entry_type;

endpackage

`default_nettype wire

/* hw/rtl/pofb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pofb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/pulsed_output_force_bank_core.sv */
// Pulsed output force bank: top level with the request sequencer, the
// channel update logic and the response register.
// Depends on pofb_pkg and pofb_ram.
`default_nettype none

// How the block is used
// ---------------------
// Requests arrive on the req_ channel as one beat each: an operation, a
// channel number and its arguments. Every request produces exactly one beat
// on the rsp_ channel carrying a status and the channel's output bit, force
// mark and remaining pulse time after the operation.
// The csr_ channel writes the tick length in milliseconds; it is always
// ready and should only be written while no request is in flight.
// Each request is handled in an accept cycle and an update cycle: in the
// accept cycle the channel entry is read from the state memory (registered
// read data) and the tick decrement is multiplied out; in the update cycle
// the entry is updated, written back and the response register is loaded.
// A new request is taken only after the current one has been completed.
// The response register decouples the sides: a new request is taken while
// a finished response still waits. If the receiver stalls, the second
// request waits in its update cycle until the response register frees.
// Reset clears the per-entry valid bits, so every channel reads as all zero
// straight away; no clearing pass is needed. tick_ms returns to 20.

module pulsed_output_force_bank_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_op,
   input  wire logic [6:0]            req_channel,
   input  wire logic                  req_level,
   input  wire logic [15:0]           req_pulse_time,
   input  wire logic                  req_hold,
   input  wire logic [15:0]           req_elapsed_ticks,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pofb_pkg::status_type       rsp_status,
   output logic                       rsp_out_level,
   output logic                       rsp_forced,
   output logic [15:0]                rsp_pulse_left,
   // configuration channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [7:0]            csr_tick_ms
);

   import pofb_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]  tick_ms_ff;

   // request held for the update cycle
   logic [2:0]  op_ff;
   logic        level_ff;
   logic [15:0] pulse_time_ff;
   logic        hold_ff;
   logic        chan_ok_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [23:0] dec_ff;
   logic        entry_vld_ff;

   logic [CHANNELS-1:0] vld_ff;

   logic        accept;
   logic        complete;
   logic        chan_ok;
   logic [6:0]  chan_m1;
   logic [IDX_W-1:0] req_idx;

   entry_type   ram_rd_data;
   entry_type   cur_entry;
   entry_type   nxt_entry;
   status_type  nxt_status;
   logic        ram_wr_en;
   logic [15:0] tick_left;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic        rsp_out_level_ff;
   logic        rsp_forced_ff;
   logic [15:0] rsp_pulse_left_ff;

   // ---------------------------------------------------------------------
   // Handshakes and sequencing
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // The update cycle finishes once the response register can take a beat.
   assign complete  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign chan_ok = (req_channel != 7'd0) && (32'(req_channel) <= CHANNELS);
   assign chan_m1 = req_channel - 7'd1;
   assign req_idx = chan_m1[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (complete) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tick_ms_ff <= TICK_MS_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            tick_ms_ff <= csr_tick_ms;
         end
      end
   end

   // Request capture. The decrement for a tick is multiplied out here so
   // that the update cycle only has a compare and subtract.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         level_ff      <= req_level;
         pulse_time_ff <= req_pulse_time;
         hold_ff       <= req_hold;
         chan_ok_ff    <= chan_ok;
         idx_ff        <= req_idx;
         dec_ff        <= tick_ms_ff * req_elapsed_ticks;
         entry_vld_ff  <= vld_ff[req_idx];
      end
   end

   // ---------------------------------------------------------------------
   // State memory and its valid bits
   // ---------------------------------------------------------------------
   pofb_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (nxt_entry),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (ram_rd_data)
   );

   // A channel never written since reset reads as all zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ram_wr_en) begin
         vld_ff[idx_ff] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Channel update
   // ---------------------------------------------------------------------
   assign cur_entry = entry_vld_ff ? ram_rd_data : '0;
   assign ram_wr_en = complete && chan_ok_ff;

   // Saturating tick countdown. The subtraction is only taken when the
   // decrement fits below the timer, so its low 16 bits suffice.
   assign tick_left = ({8'd0, cur_entry.timer} >= dec_ff) ?
                      (cur_entry.timer - dec_ff[15:0]) : 16'd0;

   always_comb begin
      nxt_entry  = cur_entry;
      nxt_status = ST_OK;
      unique case (op_ff)
         OP_WRITE: begin
            if (cur_entry.forced) begin
               nxt_status = ST_REFUSED;
            end else begin
               nxt_entry.out_level = level_ff;
            end
         end
         OP_PULSE: begin
            // A forced channel ignores pulse writes without complaint.
            if (!cur_entry.forced) begin
               if (!level_ff && !hold_ff) begin
                  nxt_status = ST_REFUSED;
               end else begin
                  nxt_entry.out_level = level_ff;
                  nxt_entry.timer     = hold_ff ? 16'd0 : pulse_time_ff;
               end
            end
         end
         OP_FORCE: begin
            nxt_entry.forced    = 1'b1;
            nxt_entry.out_level = level_ff;
            nxt_entry.timer     = 16'd0;
         end
         OP_UNFORCE: begin
            if (cur_entry.forced) begin
               nxt_entry.forced = 1'b0;
               nxt_entry.timer  = 16'd0;
            end
         end
         OP_SETMARK: begin
            nxt_entry.forced = level_ff;
         end
         OP_READ: begin
            nxt_entry = cur_entry;
         end
         OP_TICK: begin
            // Only a running, driven, unforced pulse counts down.
            if ((cur_entry.timer != 16'd0) && cur_entry.out_level &&
                !cur_entry.forced) begin
               nxt_entry.timer = tick_left;
               if (tick_left == 16'd0) begin
                  nxt_entry.out_level = 1'b0;
               end
            end
         end
         default: begin
            nxt_status = ST_REFUSED;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (complete) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (complete) begin
         if (chan_ok_ff) begin
            rsp_status_ff     <= nxt_status;
            rsp_out_level_ff  <= nxt_entry.out_level;
            rsp_forced_ff     <= nxt_entry.forced;
            rsp_pulse_left_ff <= nxt_entry.timer;
         end else begin
            rsp_status_ff     <= ST_RANGE;
            rsp_out_level_ff  <= 1'b0;
            rsp_forced_ff     <= 1'b0;
            rsp_pulse_left_ff <= 16'd0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_level  = rsp_out_level_ff;
   assign rsp_forced     = rsp_forced_ff;
   assign rsp_pulse_left = rsp_pulse_left_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter the update cycle");

   a_no_write_bad_chan: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EXEC) && !chan_ok_ff) |-> !ram_wr_en)
      else $error("state memory written for an out-of-range channel");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_RANGE)) |->
         (!rsp_out_level_ff && !rsp_forced_ff && (rsp_pulse_left_ff == 16'd0)))
      else $error("out-of-range response carries channel data");

   a_complete_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      complete |=> rsp_valid_ff)
      else $error("finished request produced no response beat");

endmodule

`default_nettype wire
